// File: rtl/mbp_pkg.sv
// shared constants, codes and controller/datapath interface types for the boundary parser
package mbp_pkg;

	localparam int ByteW      = 8;
	localparam int WordW      = 64;
	localparam int NumWords   = 7;
	localparam int LenW       = 6;
	localparam int WordSelW   = 3;
	localparam int CfgIdxW    = 3;
	localparam int MinPattern = 7;
	localparam int MaxPattern = 56;
	localparam int MatchReset = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_LENGTH = 3'd0;

	// header syntax characters
	localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
	localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
	localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
	localparam logic [ByteW-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		KIND_DATA  = 3'd0,
		KIND_NAME  = 3'd1,
		KIND_VALUE = 3'd2,
		KIND_EOL   = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	// where the output byte comes from
	typedef enum logic [1:0] {
		SRC_INPUT   = 2'd0,
		SRC_PATTERN = 2'd1,
		SRC_HELD    = 2'd2,
		SRC_ZERO    = 2'd3
	} out_src_t;

	typedef struct packed {
		logic     mc_inc;
		logic     mc_clr;
		logic     sel_replay;
		logic     rep_clr;
		logic     rep_inc;
		logic     hold_load;
		logic     out_load;
		kind_t    out_kind;
		out_src_t out_src;
		logic     out_last;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic out_free;
		logic byte_hit;
		logic match_done;
		logic mc_zero;
		logic replay_last;
		logic is_colon;
		logic is_lf;
		logic is_cr;
		logic is_space;
	} sts_t;

endpackage

// File: rtl/multipart_boundary_parser.sv
// top level of the multipart body boundary parser
// a byte's result is loaded into the output register at its transfer; a broken partial match
//   first loads its held bytes from the replay state, then the byte itself from the tail state
// throughput: one body byte per cycle with the output free; a broken partial match in part
//   data stalls further input while the held bytes and then the byte itself are output
// reset: asynchronous, pattern length 7, pattern bytes zero, parser in preamble
//   with two pattern bytes counted as matched; no clearing pass
module multipart_boundary_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mbp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [mbp_pkg::WordW-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mbp_pkg::ByteW-1:0]   body_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  kind,
	output logic [mbp_pkg::ByteW-1:0]   out_byte,
	output logic                        last
);

	mbp_pkg::cmd_t cmd;
	mbp_pkg::sts_t sts;

	// parse control
	mbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// pattern match and result transfer datapath
	mbp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.body_byte (body_byte),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// File: rtl/mbp_dpath.sv
// datapath: pattern registers, match and replay counters, held byte and output register
module mbp_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbp_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [mbp_pkg::WordW-1:0]         cfg_data,
	input  logic [mbp_pkg::ByteW-1:0]         body_byte,
	input  logic                              out_stall,
	input  mbp_pkg::cmd_t                     cmd,
	output mbp_pkg::sts_t                     sts,
	output logic                              out_valid,
	output logic [2:0]                        kind,
	output logic [mbp_pkg::ByteW-1:0]         out_byte,
	output logic                              last
);

	logic [mbp_pkg::WordW-1:0]    pat_q [mbp_pkg::NumWords];
	logic [mbp_pkg::LenW-1:0]     len_q;
	logic [mbp_pkg::LenW-1:0]     mc_q;
	logic [mbp_pkg::LenW-1:0]     rep_q;
	logic [mbp_pkg::ByteW-1:0]    held_q;
	logic                         out_valid_q;
	mbp_pkg::kind_t               out_kind_q;
	logic [mbp_pkg::ByteW-1:0]    out_byte_q;
	logic                         out_last_q;

	logic [mbp_pkg::LenW-1:0]     mc_eff;
	logic [mbp_pkg::LenW-1:0]     rd_addr;
	logic [mbp_pkg::WordSelW-1:0] wsel;
	logic [mbp_pkg::ByteW-1:0]    pat_rd;
	logic [mbp_pkg::ByteW-1:0]    out_src_byte;
	logic                         len_wr;
	logic                         out_free;

	// length clamp into the legal pattern range
	function automatic logic [mbp_pkg::LenW-1:0] clamp_len(input logic [mbp_pkg::LenW-1:0] v);
		logic [mbp_pkg::LenW-1:0] r;
		r = v;
		if (v < mbp_pkg::LenW'(mbp_pkg::MinPattern)) r = mbp_pkg::LenW'(mbp_pkg::MinPattern);
		if (v > mbp_pkg::LenW'(mbp_pkg::MaxPattern)) r = mbp_pkg::LenW'(mbp_pkg::MaxPattern);
		return r;
	endfunction

	assign len_wr   = cfg_we && (cfg_index == mbp_pkg::CFG_LENGTH);
	assign out_free = !out_valid_q || !out_stall;

	// pattern byte lookup at match or replay position
	assign mc_eff  = (mc_q >= len_q) ? '0 : mc_q;
	assign rd_addr = cmd.sel_replay ? rep_q : mc_eff;
	assign wsel    = (rd_addr[5:3] == 3'd7) ? 3'd0 : rd_addr[5:3];
	assign pat_rd  = pat_q[wsel][{rd_addr[2:0], 3'b000} +: mbp_pkg::ByteW];

	// status to the controller
	always_comb begin
		sts.restart     = len_wr;
		sts.out_free    = out_free;
		sts.byte_hit    = (body_byte == pat_rd);
		sts.match_done  = (mbp_pkg::LenW'(mc_eff + 6'd1) == len_q);
		sts.mc_zero     = (mc_eff == '0);
		sts.replay_last = (rep_q == mbp_pkg::LenW'(mc_eff - 6'd1));
		sts.is_colon    = (body_byte == mbp_pkg::CH_COLON);
		sts.is_lf       = (body_byte == mbp_pkg::CH_LF);
		sts.is_cr       = (body_byte == mbp_pkg::CH_CR);
		sts.is_space    = (body_byte == mbp_pkg::CH_SPACE);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= mbp_pkg::LenW'(mbp_pkg::MinPattern);
			for (int w = 0; w < mbp_pkg::NumWords; w++) begin
				pat_q[w] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == mbp_pkg::CFG_LENGTH) begin
				len_q <= clamp_len(cfg_data[mbp_pkg::LenW-1:0]);
			end else begin
				pat_q[cfg_index - 3'd1] <= cfg_data;
			end
		end
	end

	// match and replay counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q  <= mbp_pkg::LenW'(mbp_pkg::MatchReset);
			rep_q <= '0;
		end else begin
			if (len_wr) begin
				mc_q <= mbp_pkg::LenW'(mbp_pkg::MatchReset);
			end else if (cmd.mc_clr) begin
				mc_q <= '0;
			end else if (cmd.mc_inc) begin
				mc_q <= mbp_pkg::LenW'(mc_eff + 6'd1);
			end
			if (cmd.rep_clr) begin
				rep_q <= '0;
			end else if (cmd.rep_inc) begin
				rep_q <= mbp_pkg::LenW'(rep_q + 6'd1);
			end
		end
	end

	// output byte select
	always_comb begin
		case (cmd.out_src)
			mbp_pkg::SRC_INPUT:   out_src_byte = body_byte;
			mbp_pkg::SRC_PATTERN: out_src_byte = pat_rd;
			mbp_pkg::SRC_HELD:    out_src_byte = held_q;
			default:              out_src_byte = '0;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload and held mismatch byte
	always_ff @(posedge clk) begin
		if (cmd.hold_load) begin
			held_q <= body_byte;
		end
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			out_byte_q <= out_src_byte;
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

	// checks
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q >= mbp_pkg::LenW'(mbp_pkg::MinPattern)) &&
		(len_q <= mbp_pkg::LenW'(mbp_pkg::MaxPattern)))
		else $error("pattern length out of range");
	a_mc_below_len: assert property (@(posedge clk) disable iff (!arst_n) mc_q < len_q)
		else $error("match count reached pattern length");
	a_replay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_replay |-> (rep_q < mc_eff))
		else $error("replay index past held bytes");

endmodule

// File: rtl/mbp_ctrl.sv
// controller: parse phase, replay sequencing and input acceptance
module mbp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  mbp_pkg::sts_t sts,
	output logic          in_stall,
	output mbp_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_RUN    = 3'b001,
		ST_REPLAY = 3'b010,
		ST_TAIL   = 3'b100
	} state_t;

	typedef enum logic [3:0] {
		PH_PRE   = 4'b0001,
		PH_NAME  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   vs_q, vs_d;
	logic   accept;

	assign in_stall = !((state_q == ST_RUN) && sts.out_free);
	assign accept   = in_valid && !in_stall;

	// next state and datapath commands
	always_comb begin
		state_d        = state_q;
		phase_d        = phase_q;
		vs_d           = vs_q;
		cmd            = '0;
		cmd.out_kind   = mbp_pkg::KIND_DATA;
		cmd.out_src    = mbp_pkg::SRC_INPUT;
		cmd.sel_replay = (state_q == ST_REPLAY);
		case (state_q)
			ST_RUN: begin
				if (accept) begin
					case (phase_q)
						PH_PRE, PH_DATA: begin
							if (sts.byte_hit) begin
								if (sts.match_done) begin
									if (phase_q == PH_DATA) begin
										cmd.out_load = 1'b1;
										cmd.out_kind = mbp_pkg::KIND_END;
										cmd.out_src  = mbp_pkg::SRC_ZERO;
										cmd.out_last = 1'b1;
									end
									cmd.mc_clr = 1'b1;
									vs_d       = 1'b0;
									phase_d    = PH_NAME;
								end else begin
									cmd.mc_inc = 1'b1;
								end
							end else if (phase_q == PH_DATA && !sts.mc_zero) begin
								// replay held pattern bytes, then the mismatching byte
								cmd.hold_load = 1'b1;
								cmd.rep_clr   = 1'b1;
								state_d       = ST_REPLAY;
							end else begin
								if (phase_q == PH_DATA) begin
									cmd.out_load = 1'b1;
									cmd.out_last = 1'b1;
								end
								cmd.mc_clr = 1'b1;
							end
						end
						PH_NAME: begin
							if (sts.is_colon) begin
								phase_d = PH_VALUE;
								vs_d    = 1'b0;
							end else if (sts.is_lf) begin
								phase_d = PH_DATA;
							end else if (!sts.is_cr) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = mbp_pkg::KIND_NAME;
								cmd.out_last = 1'b1;
							end
						end
						default: begin
							if (sts.is_lf) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = mbp_pkg::KIND_EOL;
								cmd.out_src  = mbp_pkg::SRC_ZERO;
								cmd.out_last = 1'b1;
								vs_d         = 1'b0;
								phase_d      = PH_NAME;
							end else if (sts.is_cr || (sts.is_space && !vs_q)) begin
								// dropped
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_kind = mbp_pkg::KIND_VALUE;
								cmd.out_last = 1'b1;
								vs_d         = 1'b1;
							end
						end
					endcase
				end
			end
			ST_REPLAY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = mbp_pkg::SRC_PATTERN;
					cmd.rep_inc  = 1'b1;
					if (sts.replay_last) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = mbp_pkg::SRC_HELD;
					cmd.out_last = 1'b1;
					cmd.mc_clr   = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
		// length write restarts the parser
		if (sts.restart) begin
			state_d = ST_RUN;
			phase_d = PH_PRE;
			vs_d    = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			phase_q <= PH_PRE;
			vs_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			vs_q    <= vs_d;
		end
	end

	// checks
	a_replay_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (phase_q == PH_DATA))
		else $error("replay outside data phase");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");
	a_tail_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL && sts.out_free) |=> (state_q == ST_RUN))
		else $error("tail transfer did not return to run");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the multipart boundary parser with a byte-level predictor
module tb_top;

	localparam int SettleCycles = 8;
	localparam int DrainLimit   = 20000;
	localparam int HoldCycles   = 400;
	localparam logic [mbp_pkg::CfgIdxW-1:0] CFG_WORD0 = 3'd1;
	localparam logic [mbp_pkg::ByteW-1:0]   CH_DASH   = 8'h2D;

	typedef enum logic [1:0] {PH_PREAMBLE, PH_NAME, PH_VALUE, PH_DATA} parse_phase_t;

	typedef struct {
		mbp_pkg::kind_t            res_kind;
		logic [mbp_pkg::ByteW-1:0] res_byte;
		logic                      res_last;
	} parsed_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [mbp_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [mbp_pkg::WordW-1:0]   cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic [mbp_pkg::ByteW-1:0]   body_byte = '0;
	logic                        out_stall = 1'b0;
	logic                        in_stall;
	logic                        out_valid;
	logic [2:0]                  kind;
	logic [mbp_pkg::ByteW-1:0]   out_byte;
	logic                        last;

	// parser model: configuration copy and state
	logic [mbp_pkg::LenW-1:0]  len_reg;
	logic [mbp_pkg::WordW-1:0] pattern_reg [mbp_pkg::NumWords];
	parse_phase_t              phase_r;
	int unsigned               matched;
	bit                        val_started;

	parsed_t                   expected_items [$];
	logic [mbp_pkg::ByteW-1:0] body_queue [$];
	logic [mbp_pkg::ByteW-1:0] boundary [$];
	int                        queued_bytes = 0;
	int                        fail_count   = 0;
	int                        hold_left    = 0;
	bit                        in_fire      = 1'b0;
	bit                        send_gaps    = 1'b1;
	bit                        recv_gaps    = 1'b1;
	bit                        hold_req     = 1'b0;

	multipart_boundary_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.body_byte (body_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #5 clk = ~clk;

	function automatic logic [mbp_pkg::ByteW-1:0] pattern_byte(input int unsigned idx);
		return pattern_reg[(idx >> 3) % mbp_pkg::NumWords][(idx % 8) * 8 +: 8];
	endfunction

	function automatic void restart_parser();
		phase_r     = PH_PREAMBLE;
		matched     = mbp_pkg::MatchReset;
		val_started = 1'b0;
	endfunction

	// work out the results of one body byte and queue them
	function automatic void parse_byte(input logic [mbp_pkg::ByteW-1:0] ch);
		parsed_t     outs [$];
		int unsigned plen;
		plen = len_reg;
		if (plen < mbp_pkg::MinPattern) plen = mbp_pkg::MinPattern;
		if (plen > mbp_pkg::MaxPattern) plen = mbp_pkg::MaxPattern;
		case (phase_r)
			PH_PREAMBLE, PH_DATA: begin
				if (matched >= plen) matched = 0;
				if (ch == pattern_byte(matched)) begin
					matched++;
					// full boundary: part end only after the first one
					if (matched == plen) begin
						if (phase_r == PH_DATA)
							outs.push_back('{mbp_pkg::KIND_END, 8'h00, 1'b0});
						matched     = 0;
						val_started = 1'b0;
						phase_r     = PH_NAME;
					end
				end else begin
					// broken match: replay held bytes, then the byte itself
					if (phase_r == PH_DATA) begin
						for (int i = 0; i < matched; i++)
							outs.push_back('{mbp_pkg::KIND_DATA, pattern_byte(i), 1'b0});
						outs.push_back('{mbp_pkg::KIND_DATA, ch, 1'b0});
					end
					matched = 0;
				end
			end
			PH_NAME: begin
				if (ch == mbp_pkg::CH_COLON) begin
					phase_r     = PH_VALUE;
					val_started = 1'b0;
				end else if (ch == mbp_pkg::CH_LF) begin
					phase_r = PH_DATA;
				end else if (ch != mbp_pkg::CH_CR) begin
					outs.push_back('{mbp_pkg::KIND_NAME, ch, 1'b0});
				end
			end
			default: begin
				if (ch == mbp_pkg::CH_LF) begin
					outs.push_back('{mbp_pkg::KIND_EOL, 8'h00, 1'b0});
					val_started = 1'b0;
					phase_r     = PH_NAME;
				end else if (ch != mbp_pkg::CH_CR &&
						!(ch == mbp_pkg::CH_SPACE && !val_started)) begin
					outs.push_back('{mbp_pkg::KIND_VALUE, ch, 1'b0});
					val_started = 1'b1;
				end
			end
		endcase
		if (outs.size() > 0) outs[outs.size() - 1].res_last = 1'b1;
		foreach (outs[i]) expected_items.push_back(outs[i]);
	endfunction

	// input side: predict on every accepted transfer
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) parse_byte(body_byte);
	end

	// output side: compare every accepted transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		parsed_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_items.size() == 0) begin
				$error("unexpected result: kind %0d, out_byte %02h, last %0b",
					kind, out_byte, last);
				fail_count++;
			end else begin
				want = expected_items.pop_front();
				if (kind !== want.res_kind) begin
					$error("kind: expected %0d, actual %0d", want.res_kind, kind);
					fail_count++;
				end
				if (out_byte !== want.res_byte) begin
					$error("out_byte: expected %02h, actual %02h", want.res_byte, out_byte);
					fail_count++;
				end
				if (last !== want.res_last) begin
					$error("last: expected %0b, actual %0b", want.res_last, last);
					fail_count++;
				end
			end
		end
	end

	// byte driver: hold the offered byte until its transfer
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (body_queue.size() == 0 || (send_gaps && $urandom_range(99) < 20)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid  <= 1'b1;
				body_byte <= body_queue.pop_front();
			end
		end
	end

	// result receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_gaps && ($urandom_range(99) < 20);
		end
	end

	task automatic write_reg(input logic [mbp_pkg::CfgIdxW-1:0] idx,
			input logic [mbp_pkg::WordW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == mbp_pkg::CFG_LENGTH) begin
			len_reg = value[mbp_pkg::LenW-1:0];
			restart_parser();
		end else begin
			pattern_reg[idx - 1] = value;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every byte is sent and every result seen, then let the block settle
	task automatic wait_quiet();
		int guard;
		guard = 0;
		while ((body_queue.size() != 0 || in_valid || expected_items.size() != 0)
				&& guard < DrainLimit) begin
			@(negedge clk);
			guard++;
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic push_byte(input logic [mbp_pkg::ByteW-1:0] b);
		body_queue.push_back(b);
		queued_bytes++;
	endtask

	task automatic push_boundary(input int from);
		for (int i = from; i < boundary.size(); i++) push_byte(boundary[i]);
	endtask

	// one header line: name, colon, optional spaces, value, line end
	task automatic push_header();
		repeat ($urandom_range(1, 4)) push_byte(8'(8'h61 + $urandom_range(25)));
		if ($urandom_range(3) == 0) push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_COLON);
		repeat ($urandom_range(0, 2)) push_byte(mbp_pkg::CH_SPACE);
		repeat ($urandom_range(0, 5))
			push_byte($urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E))
				: 8'($urandom_range(8'h80, 8'hFF)));
		// boundary text inside a header value is just value chars
		if ($urandom_range(9) == 0)
			for (int i = 2; i < boundary.size() - 2; i++) push_byte(boundary[i]);
		push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_LF);
	endtask

	// part data, clean or noisy, sometimes with a broken boundary
	task automatic push_data(input bit noise);
		logic [mbp_pkg::ByteW-1:0] b;
		int                        k;
		repeat ($urandom_range(0, 8)) begin
			b = 8'($urandom_range(255));
			if (!noise && b == mbp_pkg::CH_CR) b = CH_DASH;
			push_byte(b);
		end
		if (!noise && $urandom_range(2) == 0) begin
			k = $urandom_range(1) ? boundary.size() - 1 : $urandom_range(1, boundary.size() - 1);
			for (int i = 0; i < k; i++) push_byte(boundary[i]);
			do b = 8'($urandom_range(255)); while (b == boundary[k] || b == mbp_pkg::CH_CR);
			push_byte(b);
		end
	endtask

	task automatic push_part();
		repeat ($urandom_range(0, 2)) push_header();
		push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_LF);
		push_data($urandom_range(9) == 0);
		push_boundary(0);
	endtask

	// empty headers, then a held run one byte short of the whole boundary
	task automatic push_long_break();
		logic [mbp_pkg::ByteW-1:0] b;
		push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_LF);
		for (int i = 0; i < boundary.size() - 1; i++) push_byte(boundary[i]);
		do b = 8'($urandom_range(255)); while (b == boundary[boundary.size() - 1]);
		push_byte(b);
	endtask

	// build CR LF dashes text CR LF, random fill past its end, load all registers
	task automatic load_boundary(input int text_len, input logic [mbp_pkg::WordW-1:0] len_value);
		logic [mbp_pkg::ByteW-1:0] pat [mbp_pkg::MaxPattern];
		logic [mbp_pkg::WordW-1:0] word;
		int                        plen;
		plen = text_len + 6;
		foreach (pat[i]) pat[i] = 8'($urandom_range(255));
		pat[0] = mbp_pkg::CH_CR;
		pat[1] = mbp_pkg::CH_LF;
		pat[2] = CH_DASH;
		pat[3] = CH_DASH;
		for (int i = 0; i < text_len; i++) pat[4 + i] = 8'(8'h41 + $urandom_range(25));
		pat[plen - 2] = mbp_pkg::CH_CR;
		pat[plen - 1] = mbp_pkg::CH_LF;
		boundary.delete();
		for (int i = 0; i < plen; i++) boundary.push_back(pat[i]);
		for (int w = 0; w < mbp_pkg::NumWords; w++) begin
			for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pat[w * 8 + b];
			write_reg(CFG_WORD0 + 3'(w), word);
		end
		write_reg(mbp_pkg::CFG_LENGTH, len_value);
	endtask

	// one setting: reconfigure while idle, then a preamble and random parts
	task automatic run_phase(input int text_len, input logic [mbp_pkg::WordW-1:0] len_value,
			input int min_bytes, input bit with_junk, input bit with_hold);
		int start;
		wait_quiet();
		load_boundary(text_len, len_value);
		start = queued_bytes;
		if (with_junk) begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
			push_byte(8'h00);
			push_boundary(0);
		end else begin
			push_boundary(2);
		end
		while (queued_bytes - start < min_bytes) push_part();
		if (with_hold) hold_req = 1'b1;
	endtask

	initial begin
		logic [mbp_pkg::WordW-1:0] odd_len;
		len_reg = mbp_pkg::MinPattern;
		foreach (pattern_reg[i]) pattern_reg[i] = '0;
		restart_parser();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset pattern is all zero bytes: five zeros finish the first boundary
		repeat (5) push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'hFF);
		push_byte(mbp_pkg::CH_COLON);
		push_byte(mbp_pkg::CH_SPACE);
		push_byte(8'h78);
		push_byte(mbp_pkg::CH_SPACE);
		push_byte(mbp_pkg::CH_COLON);
		push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_LF);
		push_byte(mbp_pkg::CH_CR);
		push_byte(mbp_pkg::CH_LF);
		// held zeros replayed on a mismatch, then a full zero boundary
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'hFF);
		repeat (7) push_byte(8'h00);

		run_phase(1, 64'd7, 10, 1'b0, 1'b0);

		// no idling on either side; length below range with upper bits set
		wait_quiet();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		odd_len   = {$urandom(), $urandom()};
		odd_len[mbp_pkg::LenW-1:0] = 6'd3;
		run_phase(1, odd_len, 16, 1'b1, 1'b0);
		wait_quiet();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;

		// length above range, longest replay, with the receiver held off
		run_phase(50, 64'd63, 0, 1'b0, 1'b1);
		push_long_break();

		wait_quiet();
		if (expected_items.size() != 0) begin
			$error("%0d expected results never arrived", expected_items.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: multipart_boundary_parser.f
rtl/mbp_pkg.sv
rtl/mbp_dpath.sv
rtl/mbp_ctrl.sv
rtl/multipart_boundary_parser.sv
bench/tb_top.sv
